// ===== sv/u2d_pkg.sv =====
package u2d_pkg;

   localparam logic [7:0] UNKNOWN_GLYPH_RESET = 8'h07;
   localparam int LETTER_COUNT = 12;

   typedef struct packed {
      logic        valid;
      logic [7:0]  code;
   } u2d_result_type;

   typedef struct packed {
      logic        hit;
      logic [7:0]  glyph;
   } u2d_lookup_type;

   typedef struct packed {
      logic [10:0] point;
      logic [7:0]  glyph;
   } u2d_letter_type;

   localparam u2d_letter_type LETTER_MAP [LETTER_COUNT] = '{
      '{11'h0E7, 8'h87}, '{11'h11F, 8'h00}, '{11'h131, 8'h01}, '{11'h0F6, 8'h94},
      '{11'h15F, 8'h02}, '{11'h0FC, 8'h81}, '{11'h0C7, 8'h80}, '{11'h130, 8'h03},
      '{11'h11E, 8'h04}, '{11'h0D6, 8'h05}, '{11'h15E, 8'h06}, '{11'h0DC, 8'h9A}
   };

   // All table points are distinct, so at most one entry matches.
   function automatic u2d_lookup_type lookup_letter(input logic [10:0] point);
      u2d_lookup_type found;
      found = '0;
      for (int i = 0; i < LETTER_COUNT; i++) begin
         if (LETTER_MAP[i].point == point) begin
            found.hit   = 1'b1;
            found.glyph = LETTER_MAP[i].glyph;
         end
      end
      return found;
   endfunction

endpackage

// ===== sv/u2d_if.sv =====
interface u2d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       start_of_text;

   modport source (output valid, output text_byte, output start_of_text, input ready);
   modport sink (input valid, input text_byte, input start_of_text, output ready);
endinterface

interface u2d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] display_code;

   modport source (output valid, output display_code, input ready);
   modport sink (input valid, input display_code, output ready);
endinterface

// ===== sv/u2d_decode.sv =====
module u2d_decode
   import u2d_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     text_byte,
   input  logic           start_of_text,
   input  logic [7:0]     unknown_glyph,
   output u2d_result_type result
);

   logic [4:0] held_lead_bits_ff, held_lead_bits_in;
   logic       awaiting_second_ff, awaiting_second_in;
   logic [2:0] bytes_to_skip_ff, bytes_to_skip_in;

   logic           awaiting;
   logic [2:0]     skip_count;
   u2d_lookup_type found;

   assign awaiting   = awaiting_second_ff & ~start_of_text;
   assign skip_count = start_of_text ? 3'd0 : bytes_to_skip_ff;
   assign found      = lookup_letter({held_lead_bits_ff, text_byte[5:0]});

   always_comb begin
      held_lead_bits_in  = start_of_text ? 5'd0 : held_lead_bits_ff;
      awaiting_second_in = awaiting;
      bytes_to_skip_in   = skip_count;
      result             = '0;
      if (awaiting) begin
         awaiting_second_in = 1'b0;
         held_lead_bits_in  = 5'd0;
         result.valid       = 1'b1;
         result.code        = found.hit ? found.glyph : unknown_glyph;
      end else if (skip_count != 3'd0) begin
         bytes_to_skip_in = skip_count - 3'd1;
      end else if (text_byte != 8'd0) begin
         if (text_byte[7:5] == 3'b110) begin
            held_lead_bits_in  = text_byte[4:0];
            awaiting_second_in = 1'b1;
         end else begin
            result.valid = 1'b1;
            result.code  = text_byte;
            if (text_byte[7:3] == 5'b11111) begin
               bytes_to_skip_in = 3'd4;
            end else if (text_byte[7:4] == 4'b1111) begin
               bytes_to_skip_in = 3'd3;
            end else if (text_byte[7:5] == 3'b111) begin
               bytes_to_skip_in = 3'd2;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_bits_ff  <= 5'd0;
         awaiting_second_ff <= 1'b0;
         bytes_to_skip_ff   <= 3'd0;
      end else if (step) begin
         held_lead_bits_ff  <= held_lead_bits_in;
         awaiting_second_ff <= awaiting_second_in;
         bytes_to_skip_ff   <= bytes_to_skip_in;
      end
   end

endmodule

// ===== sv/utf8_to_display_charset.sv =====
// Each accepted input item is held in the input register, then decoded into the result register.
// Throughput: one item per cycle; the input register drains into the decode
// and result register stage whenever the result register is empty or being taken.
// Reset clears the pending sequence, the pipeline valid flags and sets the
// unknown glyph register to 7.
module utf8_to_display_charset
   import u2d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   u2d_req_if.sink     req_ch,
   u2d_rsp_if.source   rsp_ch,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic       req_valid_ff, req_valid_in;
   logic [7:0] req_byte_ff;
   logic       req_start_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_code_ff;
   logic [7:0] unknown_glyph_ff;
   logic       advance;

   u2d_result_type result;

   assign advance      = req_valid_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~req_valid_ff | advance;
   assign req_valid_in = req_ch.ready ? req_ch.valid : req_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = result.valid;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   u2d_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .text_byte     (req_byte_ff),
      .start_of_text (req_start_ff),
      .unknown_glyph (unknown_glyph_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         unknown_glyph_ff <= UNKNOWN_GLYPH_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unknown_glyph_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         req_byte_ff  <= req_ch.text_byte;
         req_start_ff <= req_ch.start_of_text;
      end
      if (advance) begin
         rsp_code_ff <= result.code;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.display_code = rsp_code_ff;

endmodule

// ===== tb/utf8_to_display_charset_tb.sv =====
`timescale 1ns / 1ps

module utf8_to_display_charset_tb;
   import u2d_pkg::*;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [7:0] csr_write_data;

   u2d_req_if req_ch ();
   u2d_rsp_if rsp_ch ();

   utf8_to_display_charset u_top (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   logic [10:0] letter_point [12] = '{
      11'h0E7, 11'h11F, 11'h131, 11'h0F6, 11'h15F, 11'h0FC,
      11'h0C7, 11'h130, 11'h11E, 11'h0D6, 11'h15E, 11'h0DC
   };
   logic [7:0] letter_glyph [12] = '{
      8'h87, 8'h00, 8'h01, 8'h94, 8'h02, 8'h81,
      8'h80, 8'h03, 8'h04, 8'h05, 8'h06, 8'h9A
   };

   logic [4:0] held_bits = '0;
   logic pair_pending = 1'b0;
   logic [2:0] skip_count = '0;
   logic [7:0] unknown_code = UNKNOWN_GLYPH_RESET;

   logic [7:0] expected_codes [$];
   logic [7:0] want_code;
   int error_count = 0;
   int bytes_sent = 0;
   bit steady_flow = 1'b0;
   bit restart_next = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL utf8_to_display_charset");
      $finish;
   end

   function automatic logic [7:0] glyph_for_point(input logic [10:0] point);
      logic [7:0] code;
      code = unknown_code;
      for (int i = 0; i < 12; i++) begin
         if (letter_point[i] == point) begin
            code = letter_glyph[i];
         end
      end
      return code;
   endfunction

   // Updates the decoder state for one accepted byte and queues its display code, if any.
   function automatic void decode_byte(input logic [7:0] b, input logic sot);
      int ones;
      ones = 0;
      if (sot) begin
         held_bits = '0;
         pair_pending = 1'b0;
         skip_count = '0;
      end
      if (pair_pending) begin
         expected_codes.push_back(glyph_for_point({held_bits, b[5:0]}));
         pair_pending = 1'b0;
         held_bits = '0;
      end else if (skip_count != 0) begin
         skip_count = skip_count - 3'd1;
      end else if (b != 8'h00) begin
         while (ones < 5 && b[7 - ones]) begin
            ones++;
         end
         if (ones == 2) begin
            held_bits = b[4:0];
            pair_pending = 1'b1;
         end else begin
            if (ones >= 3) begin
               skip_count = 3'(ones - 1);
            end
            expected_codes.push_back(b);
         end
      end
   endfunction

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 20);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic sot = 1'b0);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.text_byte <= b;
      req_ch.start_of_text <= sot;
      do @(posedge clock); while (!req_ch.ready);
      decode_byte(b, sot);
      bytes_sent++;
      gap = idle_cycles();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_unknown_glyph(input logic [7:0] code);
      csr_write_enable <= 1'b1;
      csr_write_data <= code;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      unknown_code = code;
   endtask

   task automatic test_single_bytes();
      send_byte(8'h41);
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'hBF);
      drain();
   endtask

   task automatic test_two_byte_letters();
      send_byte(8'hC3);
      send_byte(8'hA7);
      send_byte(8'hC4);
      send_byte(8'hB1);
      send_byte(8'hC0);
      send_byte(8'h80);
      // A zero second byte and one with 11 on top are both taken as the second byte.
      send_byte(8'hDF);
      send_byte(8'h00);
      send_byte(8'hC3);
      send_byte(8'hE7);
      drain();
   endtask

   task automatic test_long_leads();
      send_byte(8'hE2);
      send_byte(8'h82);
      send_byte(8'hAC);
      send_byte(8'hF0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h41);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'hC3);
      send_byte(8'hFF);
      send_byte(8'h80);
      drain();
   endtask

   task automatic test_start_of_text();
      send_byte(8'hC4);
      send_byte(8'h41, 1'b1);
      send_byte(8'hE2);
      send_byte(8'h42, 1'b1);
      drain();
   endtask

   task automatic send_random_sequence();
      int kind;
      int idx;
      int ones;
      logic [7:0] lead;
      logic sot;
      kind = $urandom_range(0, 99);
      sot = restart_next || ($urandom_range(0, 99) < 8);
      restart_next = 1'b0;
      if (kind < 30) begin
         send_byte(($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 127)), sot);
      end else if (kind < 55) begin
         idx = $urandom_range(0, 11);
         send_byte({3'b110, letter_point[idx][10:6]}, sot);
         if ($urandom_range(0, 9) == 0) begin
            send_byte({2'($urandom), letter_point[idx][5:0]});
         end else begin
            send_byte({2'b10, letter_point[idx][5:0]});
         end
      end else if (kind < 65) begin
         send_byte({3'b110, 5'($urandom)}, sot);
         send_byte(8'($urandom));
      end else if (kind < 78) begin
         ones = $urandom_range(3, 5);
         if (ones == 5) begin
            lead = 8'hF8 | 8'($urandom_range(0, 7));
         end else begin
            lead = ~(8'hFF >> ones) | (8'($urandom) & (8'hFF >> (ones + 1)));
         end
         send_byte(lead, sot);
         for (int i = 1; i < ones; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               send_byte(8'($urandom));
            end else begin
               send_byte({2'b10, 6'($urandom)});
            end
         end
      end else if (kind < 88) begin
         send_byte(8'($urandom), 1'($urandom));
      end else begin
         // Broken sequence: a lead byte cut short by the start of a new string.
         if ($urandom_range(0, 1) == 0) begin
            send_byte({3'b110, 5'($urandom)}, sot);
         end else begin
            send_byte({4'b1110, 4'($urandom)}, sot);
            if ($urandom_range(0, 1) == 0) begin
               send_byte({2'b10, 6'($urandom)});
            end
         end
         restart_next = 1'b1;
      end
   endtask

   task automatic test_random_text(input logic [7:0] glyph, input int count);
      int stop_at;
      write_unknown_glyph(glyph);
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 39) == 0) begin
            steady_flow = ~steady_flow;
         end
         send_random_sequence();
      end
      steady_flow = 1'b0;
      drain();
   endtask

   initial begin
      logic [7:0] pick;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.text_byte <= '0;
      req_ch.start_of_text <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_bytes();
      test_two_byte_letters();
      test_long_leads();
      test_start_of_text();
      test_random_text(8'hFF, 500);
      test_random_text(8'h00, 500);
      pick = 8'($urandom);
      test_random_text(pick, 500);
      if (error_count == 0) begin
         $display("PASS utf8_to_display_charset");
      end else begin
         $display("FAIL utf8_to_display_charset");
      end
      $finish;
   end

   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         n = idle_cycles();
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_codes.size() == 0) begin
            $display("%0t: unexpected display_code, expected none, actual %02h",
                     $time, rsp_ch.display_code);
            error_count++;
         end else begin
            want_code = expected_codes.pop_front();
            if (rsp_ch.display_code !== want_code) begin
               $display("%0t: display_code mismatch, expected %02h, actual %02h",
                        $time, want_code, rsp_ch.display_code);
               error_count++;
            end
         end
      end
   end

endmodule

// ===== utf8_to_display_charset.f =====
sv/u2d_pkg.sv
sv/u2d_if.sv
sv/u2d_decode.sv
sv/utf8_to_display_charset.sv
tb/utf8_to_display_charset_tb.sv
